// ===== rtl/core/bhcf_pkg.sv =====
// Shared constants and types for the binder / Hertz contact force block.
// Used by bhcf_isqrt and binder_hertz_contact_force; depends on nothing.
package bhcf_pkg;

  // Fixed field widths
  localparam int OVL_W      = 32;   // overlap, signed Q16.16
  localparam int STIFF_W    = 32;   // stiffness coefficients, unsigned Q16.16
  localparam int BT_W       = 31;   // binder thickness
  localparam int FORCE_W    = 48;   // force, signed Q32.16

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};

  // Square root of the overlap shifted up by 16 fraction bits
  localparam int SQRT_IN_W  = 48;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINDER_STIFFNESS   = CFG_IDX_W'(0),
    REG_PARTICLE_STIFFNESS = CFG_IDX_W'(1),
    REG_BINDER_THICKNESS   = CFG_IDX_W'(2),
    REG_YIELD_OVERLAP      = CFG_IDX_W'(3),
    REG_BINDER_PRESENT     = CFG_IDX_W'(4),
    REG_ADHESION_ENABLED   = CFG_IDX_W'(5)
  } cfg_idx_t;

endpackage

// ===== rtl/core/bhcf_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on bhcf_pkg for the radicand and root widths.
module bhcf_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [bhcf_pkg::SQRT_IN_W-1:0]  radicand,
  output logic                            done,
  output logic [bhcf_pkg::SQRT_OUT_W-1:0] root
);
  import bhcf_pkg::*;

  localparam int REM_W = SQRT_OUT_W + 3;
  localparam int CNT_W = $clog2(SQRT_OUT_W);

  logic [SQRT_IN_W-1:0] rad;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     rem_sh;
  logic [REM_W-1:0]     trial;
  logic [CNT_W-1:0]     count;
  logic                 busy;
  logic                 take;

  // One digit step: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[SQRT_IN_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rad   <= radicand;
        rem   <= '0;
        root  <= '0;
        count <= CNT_W'(SQRT_OUT_W - 1);
      end else if (busy) begin
        rad  <= {rad[SQRT_IN_W-3:0], 2'b00};
        rem  <= take ? (rem_sh - trial) : rem_sh;
        root <= {root[SQRT_OUT_W-2:0], take};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/binder_hertz_contact_force.sv =====
// Binder / Hertz normal contact force for one particle pair, fixed point.
// Depends on bhcf_pkg and bhcf_isqrt.
//
// Usage:
//  Input channel (in_valid / in_stall / overlap) takes one signed Q16.16 overlap
//  per simulation step. Output channel (out_valid / out_stall / contact_force /
//  bonded_now) returns one saturated Q32.16 force and the bond flag per step.
//  Registers are written through wr_en / wr_index / wr_data; the user must write
//  them only while idle, and the block does not enforce it. Writing binder_present
//  also reloads the binder link. From transaction to result, the collapse and
//  zero paths pass the collapse multiply, decide, finish and output states; the
//  spring path adds a spring multiply, and the Hertz branch adds the 24-step
//  square root, which dominates, and three passes through the shared 32x32
//  multiplier. The next overlap is taken the cycle after a result is loaded.
//  One overlap is in flight at a time; in_stall stays high from acceptance
//  until the result is loaded into the output register.
//  The output register holds a finished result while out_stall is high, and
//  the next overlap is already accepted and computed meanwhile; the block then
//  waits for the output register to free up before finishing that step.
//  Synchronous reset clears the configuration and pair state to zero, removes
//  the binder link and empties the output register; in_stall is high during reset.
module binder_hertz_contact_force (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [bhcf_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [bhcf_pkg::CFG_DATA_W-1:0]     wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bhcf_pkg::OVL_W-1:0]   overlap,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bhcf_pkg::FORCE_W-1:0] contact_force,
  output logic                                bonded_now
);
  import bhcf_pkg::*;

  localparam int SUM_W  = OVL_W + 2;
  localparam int PROD_W = 2 * STIFF_W;
  localparam int ACC_W  = PROD_W + 8;
  localparam int PH_W   = 7;   // upper bits of h^1.5 above the low word

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_COL, ST_DECIDE, ST_MUL_SPR, ST_SQRT,
    ST_MUL_HS, ST_MUL_KPL, ST_MUL_KPH, ST_ACC, ST_FIN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PATH_ZERO, PATH_COLLAPSE, PATH_SPRING, PATH_HERTZ
  } path_t;

  // Configuration
  logic [STIFF_W-1:0]      binder_stiffness;
  logic [STIFF_W-1:0]      particle_stiffness;
  logic [BT_W-1:0]         binder_thickness;
  logic signed [OVL_W-1:0] yield_overlap;
  logic                    adhesion_enabled;

  // Pair state
  logic signed [OVL_W-1:0] previous_overlap;
  logic                    bonded;
  logic                    ever_bonded;
  logic                    binder_link;

  // Per-step working registers
  state_t                    state;
  path_t                     path_q;
  logic signed [OVL_W-1:0]   h_q;
  logic                      closing_q;
  logic                      binder_br_q;
  logic                      spr_neg_q;
  logic                      spr_pos_q;
  logic [STIFF_W-1:0]        spr_mag_q;
  logic                      col_neg_q;
  logic [STIFF_W-1:0]        col_mag_q;
  logic [PROD_W-1:0]         prod_q;
  logic [PH_W-1:0]           ph_q;
  logic [ACC_W-1:0]          acc_q;
  logic signed [FORCE_W-1:0] collapse_q;
  logic signed [FORCE_W-1:0] force_q;

  logic [SUM_W-1:0]          sum_spr;
  logic [SUM_W-1:0]          sum_col;
  logic [STIFF_W-1:0]        mul_a;
  logic [STIFF_W-1:0]        mul_b;
  logic [PROD_W-1:0]         mul_p;
  path_t                     decide_path;
  logic [ACC_W-17:0]         hertz_q;
  logic signed [FORCE_W-1:0] hertz_f;
  logic signed [FORCE_W-1:0] fin_force;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [SQRT_OUT_W-1:0]     sqrt_root;
  logic [SQRT_IN_W-1:0]      sqrt_in;

  // Magnitude of a signed sum; it always fits the multiplier operand
  function automatic logic [STIFF_W-1:0] mag_of(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] n;
    n = -s;
    return s[SUM_W-1] ? n[STIFF_W-1:0] : s[STIFF_W-1:0];
  endfunction

  // floor(k*a / 2^16) from sign and unsigned product, saturated high
  function automatic logic signed [FORCE_W-1:0] spring_fix(input logic neg,
                                                          input logic [PROD_W-1:0] p);
    logic [PROD_W:0] up;
    up = {1'b0, p} + (PROD_W+1)'(16'hFFFF);
    if (neg)
      return FORCE_W'(0) - up[PROD_W-1:16];
    else if (p[PROD_W-1])
      return FORCE_MAX;
    else
      return p[PROD_W-1:16];
  endfunction

  // Binder sums at acceptance time
  always_comb begin
    sum_spr = {{2{overlap[OVL_W-1]}}, overlap} + {3'b000, binder_thickness};
    sum_col = {{2{yield_overlap[OVL_W-1]}}, yield_overlap} + {3'b000, binder_thickness};
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_COL: begin
        mul_a = binder_stiffness;
        mul_b = col_mag_q;
      end
      ST_MUL_SPR: begin
        mul_a = binder_stiffness;
        mul_b = spr_mag_q;
      end
      ST_MUL_HS: begin
        mul_a = {1'b0, h_q[OVL_W-2:0]};
        mul_b = {{(STIFF_W-SQRT_OUT_W){1'b0}}, sqrt_root};
      end
      ST_MUL_KPL: begin
        mul_a = particle_stiffness;
        mul_b = prod_q[STIFF_W+15:16];
      end
      ST_MUL_KPH: begin
        mul_a = particle_stiffness;
        mul_b = {{(STIFF_W-PH_W){1'b0}}, ph_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Branch choice for this step
  always_comb begin
    if (binder_br_q) begin
      if (spr_pos_q || bonded)
        decide_path = (h_q > yield_overlap) ? PATH_COLLAPSE : PATH_SPRING;
      else
        decide_path = PATH_ZERO;
    end else begin
      decide_path = h_q[OVL_W-1] ? PATH_ZERO : PATH_HERTZ;
    end
  end

  // Hertz force with saturation, then final force select
  always_comb begin
    hertz_q = acc_q[ACC_W-1:16];
    hertz_f = (|hertz_q[ACC_W-17:FORCE_W-1]) ? FORCE_MAX
                                             : signed'(hertz_q[FORCE_W-1:0]);
    case (path_q)
      PATH_COLLAPSE: fin_force = collapse_q;
      PATH_SPRING:   fin_force = spring_fix(spr_neg_q, prod_q);
      PATH_HERTZ:    fin_force = (hertz_f < collapse_q && closing_q && ever_bonded)
                                 ? collapse_q : hertz_f;
      default:       fin_force = '0;
    endcase
  end

  // Square root of h in Q16.16: radicand is h shifted up by 16
  assign sqrt_in    = {1'b0, h_q[OVL_W-2:0], 16'h0000};
  assign sqrt_start = (state == ST_DECIDE) && (decide_path == PATH_HERTZ);

  bhcf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign in_stall = rst || (state != ST_IDLE);

  // Sequencer, configuration, pair state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      binder_stiffness   <= '0;
      particle_stiffness <= '0;
      binder_thickness   <= '0;
      yield_overlap      <= '0;
      adhesion_enabled   <= 1'b0;
      previous_overlap   <= '0;
      bonded             <= 1'b0;
      ever_bonded        <= 1'b0;
      binder_link        <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (out_valid && !out_stall && state != ST_OUT)
        out_valid <= 1'b0;

      if (wr_en) begin
        case (cfg_idx_t'(wr_index))
          REG_BINDER_STIFFNESS:   binder_stiffness   <= wr_data;
          REG_PARTICLE_STIFFNESS: particle_stiffness <= wr_data;
          REG_BINDER_THICKNESS:   binder_thickness   <= wr_data[BT_W-1:0];
          REG_YIELD_OVERLAP:      yield_overlap      <= signed'(wr_data);
          REG_BINDER_PRESENT:     binder_link        <= wr_data[0];
          REG_ADHESION_ENABLED:   adhesion_enabled   <= wr_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            h_q              <= overlap;
            closing_q        <= (overlap >= previous_overlap);
            previous_overlap <= overlap;
            binder_br_q      <= binder_link && overlap[OVL_W-1];
            spr_neg_q        <= sum_spr[SUM_W-1];
            spr_pos_q        <= !sum_spr[SUM_W-1] && (sum_spr != '0);
            spr_mag_q        <= mag_of(sum_spr);
            col_neg_q        <= sum_col[SUM_W-1];
            col_mag_q        <= mag_of(sum_col);
            state            <= ST_MUL_COL;
          end
        end
        ST_MUL_COL: begin
          prod_q <= mul_p;
          state  <= ST_DECIDE;
        end
        ST_DECIDE: begin
          collapse_q <= spring_fix(col_neg_q, prod_q);
          path_q     <= decide_path;
          case (decide_path)
            PATH_SPRING: state <= ST_MUL_SPR;
            PATH_HERTZ:  state <= ST_SQRT;
            default:     state <= ST_FIN;
          endcase
        end
        ST_MUL_SPR: begin
          prod_q <= mul_p;
          state  <= ST_FIN;
        end
        ST_SQRT: begin
          if (sqrt_done)
            state <= ST_MUL_HS;
        end
        ST_MUL_HS: begin
          prod_q <= mul_p;
          state  <= ST_MUL_KPL;
        end
        ST_MUL_KPL: begin
          // low word of h^1.5 goes through now, upper bits next
          ph_q   <= prod_q[STIFF_W+16+PH_W-1:STIFF_W+16];
          prod_q <= mul_p;
          state  <= ST_MUL_KPH;
        end
        ST_MUL_KPH: begin
          acc_q  <= {8'h00, prod_q};
          prod_q <= mul_p;
          state  <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= acc_q + {prod_q[ACC_W-STIFF_W-1:0], {STIFF_W{1'b0}}};
          state <= ST_FIN;
        end
        ST_FIN: begin
          force_q <= fin_force;
          if (binder_br_q) begin
            if (fin_force > 0 && adhesion_enabled) begin
              bonded      <= 1'b1;
              ever_bonded <= 1'b1;
            end
          end else begin
            // leaving the binder branch breaks the bond and the link
            bonded      <= 1'b0;
            binder_link <= 1'b0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            contact_force <= force_q;
            bonded_now    <= bonded;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
